// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on i_clk of the using module, off while i_rst_n is low.
`define PFGR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk of the using module, off while i_rst_n is low.
`define PFGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pfgr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfgr_pkg
// Screen geometry, opcodes and address helper for the page framebuffer.
// ----------------------------------------------------------------------------
package pfgr_pkg;

    localparam int SCREEN_WIDTH = 128;
    localparam int SCREEN_PAGES = 4;
    localparam int PAGE_ROWS    = 8;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 8;
    localparam int SCREEN_ROWS  = SCREEN_PAGES * PAGE_ROWS;
    localparam int STORE_BYTES  = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PAGE_W       = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_GLYPH = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    // Linear byte address of (page, column).
    function automatic logic [ADDR_W-1:0] fb_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [7:0] col);
        return ADDR_W'(32'(page) * 32'(SCREEN_WIDTH) + 32'(col));
    endfunction

endpackage

// ----- sv/pfgr_if.sv -----
// ----------------------------------------------------------------------------
// pfgr channel interfaces
// Valid/ready channels for operation requests and read responses.
// ----------------------------------------------------------------------------
interface pfgr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        pixel_on;
    logic [39:0] glyph_columns;
    logic [3:0]  glyph_scale;
    logic [8:0]  read_index;

    modport source (output valid, opcode, pos_x, pos_y, pixel_on, glyph_columns,
                    glyph_scale, read_index, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pixel_on, glyph_columns,
                    glyph_scale, read_index, output ready);
endinterface

interface pfgr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

// ----- sv/pfgr_ram.sv -----
// ----------------------------------------------------------------------------
// pfgr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/page_framebuffer_glyph_renderer_core.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_renderer_core
// Page-organized monochrome framebuffer with pixel, scaled glyph, clear and
// read operations on one byte-wide RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transaction carries
//  -------  ---  -------------------------------------------------------------
//  i_req    in   opcode, pos_x, pos_y, pixel_on, glyph_columns, glyph_scale,
//                read_index
//  o_rsp    out  read_data (one per read transaction, none otherwise)
//
//  Transaction timing is set by the single RAM read port (one byte
//  read-modify-write per cycle):
//    clear  one write per cycle over the store        pixel  one RMW
//    read   S_READ then S_RDATA (waits if o_rsp holds an earlier byte)
//    glyph  row expansion, then one RMW per page byte; nothing for scale 0
//  Reset runs the same clearing pass with i_req.ready low.
//  o_rsp is a register: a stalled response only blocks a later read from
//  finishing.
//
module page_framebuffer_glyph_renderer_core
    import pfgr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfgr_req_if.sink     i_req,
    pfgr_rsp_if.source   o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_PIXEL  = 7'b0000100,
        S_EXPAND = 7'b0001000,
        S_BLIT   = 7'b0010000,
        S_READ   = 7'b0100000,
        S_RDATA  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Operation operands, captured on accept.
    logic [7:0]        r_x, n_x;
    logic [7:0]        r_y, n_y;
    logic              r_on, n_on;
    logic [39:0]       r_cols, n_cols;
    logic [3:0]        r_scale, n_scale;
    logic [ADDR_W-1:0] r_ridx, n_ridx;
    logic              r_rd_oob, n_rd_oob;

    // Clear sweep pointer.
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    // Glyph walk counters: row expansion reuses r_sub, column walk too.
    logic [7:0]        r_ycur, n_ycur;
    logic [2:0]        r_row, n_row;
    logic [3:0]        r_sub, n_sub;
    logic [2:0]        r_col, n_col;
    logic [PAGE_W-1:0] r_page, n_page;

    // Row map: for each on-screen row, whether the glyph covers it and which
    // glyph row lands there. Kept per page, one bit/row-select per pixel row.
    logic [7:0] r_rmask [SCREEN_PAGES];
    logic [7:0] n_rmask [SCREEN_PAGES];
    logic [2:0] r_rsel  [SCREEN_PAGES][PAGE_ROWS];
    logic [2:0] n_rsel  [SCREEN_PAGES][PAGE_ROWS];

    // Write-back stage of the read-modify-write.
    logic              r_wb_valid, n_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr, n_wb_addr;
    logic [7:0]        r_wb_mask, n_wb_mask;
    logic [7:0]        r_wb_val, n_wb_val;

    // Response register.
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_data, n_out_data;

    // Issue side of the RMW and RAM port signals.
    logic              iss_valid;
    logic [ADDR_W-1:0] iss_addr;
    logic [7:0]        iss_mask;
    logic [7:0]        iss_val;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [7:0]        ram_rd_data;

    logic       req_fire;
    logic       x_on_screen;
    logic       y_on_screen;
    logic       sub_last;
    logic       page_last;
    logic [7:0] col_bits;
    logic [7:0] pg_mask;
    logic [7:0] pg_val;

    assign req_fire    = i_req.valid && i_req.ready;
    assign x_on_screen = (r_x < 8'(SCREEN_WIDTH));
    assign y_on_screen = (r_y < 8'(SCREEN_ROWS));
    assign sub_last    = (r_sub == (r_scale - 4'd1));
    assign page_last   = (r_page == PAGE_W'(SCREEN_PAGES - 1));

    // Byte for the current page of the current screen column: every covered
    // row takes its glyph bit, uncovered rows keep the stored value.
    assign col_bits = r_cols[{r_col, 3'b000} +: 8];
    assign pg_mask  = r_rmask[r_page];
    always_comb begin
        for (int b = 0; b < PAGE_ROWS; b++) begin
            pg_val[b] = col_bits[r_rsel[r_page][b]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_on        = r_on;
        n_cols      = r_cols;
        n_scale     = r_scale;
        n_ridx      = r_ridx;
        n_rd_oob    = r_rd_oob;
        n_clr_addr  = r_clr_addr;
        n_ycur      = r_ycur;
        n_row       = r_row;
        n_sub       = r_sub;
        n_col       = r_col;
        n_page      = r_page;
        n_rmask     = r_rmask;
        n_rsel      = r_rsel;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        iss_valid   = 1'b0;
        iss_addr    = fb_addr(r_page, r_x);
        iss_mask    = pg_mask;
        iss_val     = pg_val;
        ram_rd_en   = 1'b0;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_x      = i_req.pos_x;
                    n_y      = i_req.pos_y;
                    n_on     = i_req.pixel_on;
                    n_cols   = i_req.glyph_columns;
                    n_scale  = i_req.glyph_scale;
                    n_ridx   = ADDR_W'(i_req.read_index);
                    n_rd_oob = (32'(i_req.read_index) >= 32'(STORE_BYTES));
                    n_ycur   = i_req.pos_y;
                    n_row    = 3'd0;
                    n_sub    = 4'd0;
                    n_col    = 3'd0;
                    n_page   = '0;
                    case (t_opcode'(i_req.opcode))
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_PIXEL: n_state = S_PIXEL;
                        OP_GLYPH: begin
                            n_state = S_EXPAND;
                            for (int p = 0; p < SCREEN_PAGES; p++) begin
                                n_rmask[p] = 8'h00;
                            end
                        end
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end

            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                    n_clr_addr = '0;
                    n_state    = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end

            S_PIXEL: begin
                iss_valid = x_on_screen && y_on_screen;
                iss_addr  = fb_addr(r_y[PAGE_W+2:3], r_x);
                iss_mask  = 8'h01 << r_y[2:0];
                iss_val   = {8{r_on}};
                n_state   = S_IDLE;
            end

            // Walk the 8*scale glyph rows down from pos_y (wrapping at 256)
            // and record which glyph row covers each on-screen pixel row.
            S_EXPAND: begin
                if (r_scale == 4'd0) begin
                    n_state = S_IDLE;
                end else begin
                    if (r_ycur < 8'(SCREEN_ROWS)) begin
                        n_rmask[r_ycur[PAGE_W+2:3]][r_ycur[2:0]] = 1'b1;
                        n_rsel[r_ycur[PAGE_W+2:3]][r_ycur[2:0]]  = r_row;
                    end
                    n_ycur = r_ycur + 8'd1;
                    if (sub_last) begin
                        n_sub = 4'd0;
                        if (r_row == 3'(GLYPH_ROWS - 1)) begin
                            n_state = S_BLIT;
                        end else begin
                            n_row = r_row + 3'd1;
                        end
                    end else begin
                        n_sub = r_sub + 4'd1;
                    end
                end
            end

            // One page byte per cycle over 5*scale screen columns. Every
            // (column, page) pair is a distinct address, so a read never
            // overlaps the write-back of the same byte.
            S_BLIT: begin
                iss_valid = x_on_screen && (pg_mask != 8'h00);
                if (page_last) begin
                    n_page = '0;
                    n_x    = r_x + 8'd1;
                    if (sub_last) begin
                        n_sub = 4'd0;
                        if (r_col == 3'(GLYPH_COLS - 1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_col = r_col + 3'd1;
                        end
                    end else begin
                        n_sub = r_sub + 4'd1;
                    end
                end else begin
                    n_page = r_page + PAGE_W'(1);
                end
            end

            S_READ: begin
                ram_rd_en = 1'b1;
                n_state   = S_RDATA;
            end

            // RAM output holds while the response register is still full.
            S_RDATA: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_oob ? 8'h00 : ram_rd_data;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (iss_valid) begin
            ram_rd_en = 1'b1;
        end
    end

    assign n_wb_valid = iss_valid;
    assign n_wb_addr  = iss_addr;
    assign n_wb_mask  = iss_mask;
    assign n_wb_val   = iss_val;

    // Write port: clear sweep, or the merge of the byte read last cycle.
    // Every transaction passes S_IDLE before a clear, so a write-back never meets the sweep.
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = 8'h00;
        end else begin
            ram_we      = r_wb_valid;
            ram_wr_addr = r_wb_addr;
            ram_wr_data = (ram_rd_data & ~r_wb_mask) | (r_wb_val & r_wb_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
        end
        r_x        <= n_x;
        r_y        <= n_y;
        r_on       <= n_on;
        r_cols     <= n_cols;
        r_scale    <= n_scale;
        r_ridx     <= n_ridx;
        r_rd_oob   <= n_rd_oob;
        r_ycur     <= n_ycur;
        r_row      <= n_row;
        r_sub      <= n_sub;
        r_col      <= n_col;
        r_page     <= n_page;
        r_rmask    <= n_rmask;
        r_rsel     <= n_rsel;
        r_wb_addr  <= n_wb_addr;
        r_wb_mask  <= n_wb_mask;
        r_wb_val   <= n_wb_val;
        r_out_data <= n_out_data;
    end

    pfgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr ((r_state == S_READ) ? r_ridx : iss_addr),
        .o_rd_data (ram_rd_data)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

endmodule

// ----- sv/pfgr_checker.sv -----
// ----------------------------------------------------------------------------
// pfgr_checker
// Port-level checks on request/response timing of the framebuffer core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfgr_checker
    import pfgr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_opcode,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_rsp_data
);

    logic req_fire;
    logic read_fire;
    logic read_idle;
    logic quiet_fire;
    logic rsp_stall;
    logic rsp_idle;

    assign req_fire   = i_req_valid && i_req_ready;
    assign read_fire  = req_fire && (i_req_opcode == OP_READ);
    assign read_idle  = read_fire && !i_rsp_valid;
    assign quiet_fire = req_fire && (i_req_opcode != OP_READ) && !i_rsp_valid;
    assign rsp_stall  = i_rsp_valid && !i_rsp_ready;
    assign rsp_idle   = !i_rsp_valid;

    // Stalled response holds.
    `PFGR_ASSERT_NEXT(a_rsp_hold, rsp_stall, i_rsp_valid && $stable(i_rsp_data), "rsp not held")

    // The core is busy in the cycle after every accepted transaction.
    `PFGR_ASSERT_NEXT(a_busy_after_req, req_fire, !i_req_ready, "request taken while busy")

    // A read into an empty response register passes S_READ and S_RDATA, then shows valid.
    `PFGR_ASSERT_IMPL(a_read_latency, read_idle, ##3 i_rsp_valid, "read response late")

    // Non-read transactions produce no response.
    `PFGR_ASSERT_NEXT(a_no_rsp, quiet_fire, rsp_idle ##1 rsp_idle ##1 rsp_idle, "stray rsp")

endmodule

bind page_framebuffer_glyph_renderer_core pfgr_checker u_pfgr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_opcode (i_req.opcode),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.read_data)
);

// ----- test/page_framebuffer_glyph_renderer_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_renderer_core_test
// Sends clear, pixel, scaled glyph and read transactions to the framebuffer
// core and checks each returned byte against a mirror of the frame store.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_renderer_core_test
    import pfgr_pkg::*;
();

    typedef struct {
        t_opcode     op;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic        pixel_on;
        logic [39:0] glyph_columns;
        logic [3:0]  glyph_scale;
        logic [8:0]  read_index;
    } t_fb_op;

    // Mirror of the frame store plus the bytes still owed on o_rsp.
    class t_frame_mirror;
        bit [7:0]    mem [STORE_BYTES];
        bit [7:0]    exp_bytes [$];
        int unsigned mismatches;

        function new();
            wipe();
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (mem[i]) mem[i] = 8'h00;
        endfunction

        // Coordinates wrap to 8 bits first, then anything off screen is dropped.
        function void plot(int x, int y, bit on);
            int xb;
            int yb;
            int idx;
            xb = x & 255;
            yb = y & 255;
            if (xb >= SCREEN_WIDTH || yb >= SCREEN_ROWS) return;
            idx = (yb / PAGE_ROWS) * SCREEN_WIDTH + xb;
            if (idx >= STORE_BYTES) return;
            mem[idx][yb % PAGE_ROWS] = on;
        endfunction

        // Background pixels are written too; scale 0 leaves the loops empty.
        function void blit(int x0, int y0, logic [39:0] cols, int scale);
            bit [7:0] bits;
            for (int c = 0; c < GLYPH_COLS; c++) begin
                bits = cols[8*c +: 8];
                for (int sx = 0; sx < scale; sx++)
                    for (int r = 0; r < GLYPH_ROWS; r++)
                        for (int sy = 0; sy < scale; sy++)
                            plot(x0 + c*scale + sx, y0 + r*scale + sy, bits[r]);
            end
        endfunction

        function void note_request(t_fb_op t);
            case (t.op)
                OP_CLEAR: wipe();
                OP_PIXEL: plot(t.pos_x, t.pos_y, t.pixel_on);
                OP_GLYPH: blit(t.pos_x, t.pos_y, t.glyph_columns, t.glyph_scale);
                default: begin
                    if (int'(t.read_index) < STORE_BYTES)
                        exp_bytes.push_back(mem[t.read_index]);
                    else
                        exp_bytes.push_back(8'h00);
                end
            endcase
        endfunction

        function void check_read(logic [7:0] got);
            bit [7:0] want;
            if (exp_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: read_data %h arrived with no read outstanding",
                             $realtime, got);
            end else begin
                want = exp_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: read_data expected %h, got %h",
                                 $realtime, want, got);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pfgr_req_if req_ch ();
    pfgr_rsp_if rsp_ch ();

    page_framebuffer_glyph_renderer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_frame_mirror fb_ref;
    int unsigned snd_idle_pct = 15;
    int unsigned rcv_idle_pct = 59;
    bit          rsp_hold_go  = 1'b0;   // asks the response side for a long hold-off
    int unsigned last_idx     = 0;      // byte touched by the latest on-screen pixel

    always #5ns i_clk = ~i_clk;

    // Watchdog. Even if every transaction were a full clear the run would
    // end before it fires.
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_fb_op mk(t_opcode op, int x, int y, bit on,
                                  logic [39:0] cols, int scale, int idx);
        t_fb_op t;
        t.op            = op;
        t.pos_x         = 8'(x);
        t.pos_y         = 8'(y);
        t.pixel_on      = on;
        t.glyph_columns = cols;
        t.glyph_scale   = 4'(scale);
        t.read_index    = 9'(idx);
        return t;
    endfunction

    // Fields unused by the chosen op stay random so every bit toggles.
    function automatic t_fb_op rand_op();
        t_fb_op      t;
        int unsigned pick;
        t.pos_x         = 8'($urandom);
        t.pos_y         = 8'($urandom);
        t.pixel_on      = 1'($urandom);
        t.glyph_columns = {8'($urandom), 32'($urandom)};
        t.glyph_scale   = 4'($urandom);
        t.read_index    = 9'($urandom);
        pick = $urandom_range(99);
        if (pick < 2) begin
            t.op = OP_CLEAR;
        end else if (pick < 36) begin
            t.op = OP_PIXEL;
            if ($urandom_range(99) < 85) begin
                t.pos_x  = 8'($urandom_range(SCREEN_WIDTH - 1));
                t.pos_y  = 8'($urandom_range(SCREEN_ROWS - 1));
                last_idx = (t.pos_y / PAGE_ROWS) * SCREEN_WIDTH + t.pos_x;
            end
        end else if (pick < 58) begin
            t.op = OP_GLYPH;
            // mostly cheap scales; big ones are slow
            pick = $urandom_range(99);
            if (pick < 10)
                t.glyph_scale = 4'd0;
            else if (pick < 90)
                t.glyph_scale = 4'($urandom_range(3, 1));
            if ($urandom_range(99) < 75) begin
                t.pos_x = 8'($urandom_range(SCREEN_WIDTH - 1));
                t.pos_y = 8'($urandom_range(SCREEN_ROWS - 1));
            end
        end else begin
            t.op = OP_READ;
            if ($urandom_range(99) < 40)
                t.read_index = 9'(last_idx);
        end
        return t;
    endfunction

    // valid is only dropped when the sender decides to idle, so it never sees
    // two assignments in one time step.
    task automatic offer_op(input t_fb_op t);
        if ($urandom_range(99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= t.op;
        req_ch.pos_x         <= t.pos_x;
        req_ch.pos_y         <= t.pos_y;
        req_ch.pixel_on      <= t.pixel_on;
        req_ch.glyph_columns <= t.glyph_columns;
        req_ch.glyph_scale   <= t.glyph_scale;
        req_ch.read_index    <= t.read_index;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        fb_ref.note_request(t);
    endtask

    // Response side: checks each transaction, then picks next cycle's ready.
    initial begin : rsp_side
        int unsigned hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                fb_ref.check_read(rsp_ch.read_data);
            if (hold_left == 0 && rsp_hold_go) begin
                hold_left   = 400;
                rsp_hold_go = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin : req_side
        fb_ref = new();
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_CLEAR;
        req_ch.pos_x         <= 8'h00;
        req_ch.pos_y         <= 8'h00;
        req_ch.pixel_on      <= 1'b0;
        req_ch.glyph_columns <= 40'h0;
        req_ch.glyph_scale   <= 4'h0;
        req_ch.read_index    <= 9'h000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // offer_op waits out the post-reset clearing pass on ready

        // -- directed --
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 0));      // store empty after reset
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, STORE_BYTES - 1));
        offer_op(mk(OP_PIXEL, 0,   0,   1, 40'h0, 0, 0));      // top-left corner
        offer_op(mk(OP_PIXEL, 127, 31,  1, 40'h0, 0, 0));      // bottom-right corner
        offer_op(mk(OP_PIXEL, 128, 0,   1, 40'h0, 0, 0));      // just right of screen
        offer_op(mk(OP_PIXEL, 0,   32,  1, 40'h0, 0, 0));      // just below screen
        offer_op(mk(OP_PIXEL, 255, 255, 1, 40'h0, 0, 0));      // far corner, off screen
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, STORE_BYTES - 1));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, SCREEN_WIDTH));
        offer_op(mk(OP_PIXEL, 0,   0,   0, 40'h0, 0, 0));      // clear a set bit
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 0));
        offer_op(mk(OP_GLYPH, 0,   0,   0, 40'hFF_00_AA_55_81, 1, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 2));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 4));
        offer_op(mk(OP_GLYPH, 10,  0,   0, 40'hFF_FF_FF_FF_FF, 0, 0)); // zero scale
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 10));
        // largest scale, both coordinates wrap past 255
        offer_op(mk(OP_GLYPH, 250, 250, 0, 40'hFF_FF_FF_FF_FF, 15, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 3 * SCREEN_WIDTH + 60));
        offer_op(mk(OP_GLYPH, 100, 8,   0, 40'h1F_2E_3C_4A_58, 2, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, SCREEN_WIDTH + 100));
        offer_op(mk(OP_CLEAR, 0,   0,   0, 40'h0, 0, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, 0));
        offer_op(mk(OP_READ,  0,   0,   0, 40'h0, 0, STORE_BYTES - 1));

        // -- random, sender lightly idle, receiver mostly stalled --
        repeat (500) offer_op(rand_op());

        // -- random, roles swapped --
        snd_idle_pct = 59;
        rcv_idle_pct = 15;
        repeat (500) offer_op(rand_op());

        // -- back-to-back; long receiver hold-off backs reads up into i_req --
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        rsp_hold_go  = 1'b1;
        repeat (24) offer_op(mk(OP_READ, 0, 0, 0, 40'h0, 0,
                                $urandom_range(STORE_BYTES - 1)));
        repeat (500) offer_op(rand_op());

        req_ch.valid <= 1'b0;
        while (fb_ref.exp_bytes.size() != 0) @(posedge i_clk);
        // a trailing clear or glyph may still be running; catch stray responses
        repeat (STORE_BYTES + 32) @(posedge i_clk);

        if (fb_ref.mismatches == 0 && fb_ref.exp_bytes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
